>>> design/assert_macros.svh
// Assertion helper macros for the support point picker.
// No dependencies; included by the RTL files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> design/tmcsp_pkg.sv
// Shared types and constants for the tile minimum-cost support point picker.
// No dependencies.
package tmcsp_pkg;

  localparam int CostW  = 16;
  localparam int PointW = 12;
  localparam int DimW   = 13;

  // register indexes on the configuration port
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_VALID_LIMIT  = 2'd2;
  localparam logic [1:0] REG_ACCEPT_LIMIT = 2'd3;

  localparam logic [DimW-1:0]  RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DimW-1:0]  RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [CostW-1:0] RST_VALID_LIMIT  = 16'd32768;
  localparam logic [CostW-1:0] RST_ACCEPT_LIMIT = 16'd1638;

  // result queue
  localparam int OutDepth = 4;
  localparam int OutPtrW  = 2;
  localparam int OutLvlW  = 3;

  typedef struct packed {
    logic [PointW-1:0] y;
    logic [PointW-1:0] x;
  } point_t;

endpackage

>>> design/tile_min_cost_support_points_unit.sv
// Top level of the tile minimum-cost support point picker.
// Depends on tmcsp_pkg and tmcsp_out_fifo.
//
// Takes one pixel cost per cycle in column-major order and sustains one pixel
// per clock. Each pixel is a read-modify-write of its tile's slot in a band
// memory of ceil(MAX_DIMENSION / TILE_SIZE) entries: the slot is read at the
// accept edge and written back in the following cycle, with the written value
// forwarded when the next pixel hits the same slot. A support point is pushed
// from the update stage into a four-entry result queue and shown on m_tdata
// from there; s_tready drops only when that queue could fill.
// No clearing pass after reset: each slot is loaded on its tile's first pixel.
// Configuration should be written only while no pixel is in flight.
`include "assert_macros.svh"

module tile_min_cost_support_points_unit #(
  parameter int TILE_SIZE     = 5,
  parameter int MAX_DIMENSION = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // pixel input; tdata: [15:0] pixel_cost
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // support points; tdata: [11:0] point_x, [23:12] point_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int BandDepth = (MAX_DIMENSION + TILE_SIZE - 1) / TILE_SIZE;
  localparam int SlotW     = (BandDepth > 1) ? $clog2(BandDepth) : 1;
  localparam int CoordW    = $clog2(MAX_DIMENSION);
  localparam int PhaseW    = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
  localparam int ExtW      = (CoordW > tmcsp_pkg::PointW) ? CoordW : tmcsp_pkg::PointW;
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(TILE_SIZE - 1);

  typedef struct packed {
    logic [tmcsp_pkg::CostW-1:0] cost;
    logic [CoordW-1:0]           x;
    logic [CoordW-1:0]           y;
  } slot_t;

  // configuration registers
  logic [tmcsp_pkg::DimW-1:0]  image_width;
  logic [tmcsp_pkg::DimW-1:0]  image_height;
  logic [tmcsp_pkg::CostW-1:0] valid_limit;
  logic [tmcsp_pkg::CostW-1:0] accept_limit;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= tmcsp_pkg::RST_IMAGE_WIDTH;
      image_height <= tmcsp_pkg::RST_IMAGE_HEIGHT;
      valid_limit  <= tmcsp_pkg::RST_VALID_LIMIT;
      accept_limit <= tmcsp_pkg::RST_ACCEPT_LIMIT;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        tmcsp_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[tmcsp_pkg::DimW-1:0];
        tmcsp_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[tmcsp_pkg::DimW-1:0];
        tmcsp_pkg::REG_VALID_LIMIT:  valid_limit  <= pwdata[tmcsp_pkg::CostW-1:0];
        tmcsp_pkg::REG_ACCEPT_LIMIT: accept_limit <= pwdata[tmcsp_pkg::CostW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tmcsp_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      tmcsp_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      tmcsp_pkg::REG_VALID_LIMIT:  prdata = 32'(valid_limit);
      tmcsp_pkg::REG_ACCEPT_LIMIT: prdata = 32'(accept_limit);
    endcase
  end

  // last column / row index after clamping the dimensions to 1..MAX_DIMENSION
  logic [31:0]       width_ext;
  logic [31:0]       height_ext;
  logic [CoordW-1:0] col_last;
  logic [CoordW-1:0] row_last;

  assign width_ext  = 32'(image_width);
  assign height_ext = 32'(image_height);

  always_comb begin
    priority if (width_ext == 32'd0) begin
      col_last = '0;
    end else if (width_ext > 32'(MAX_DIMENSION)) begin
      col_last = CoordW'(MAX_DIMENSION - 1);
    end else begin
      col_last = CoordW'(width_ext - 32'd1);
    end
    priority if (height_ext == 32'd0) begin
      row_last = '0;
    end else if (height_ext > 32'(MAX_DIMENSION)) begin
      row_last = CoordW'(MAX_DIMENSION - 1);
    end else begin
      row_last = CoordW'(height_ext - 32'd1);
    end
  end

  // scan position
  logic [CoordW-1:0] col;
  logic [CoordW-1:0] row;
  logic [PhaseW-1:0] col_phase;
  logic [PhaseW-1:0] row_phase;
  logic [SlotW-1:0]  slot;
  logic              accept;
  logic              at_col_end;
  logic              at_row_end;
  logic              tile_start;
  logic              tile_last;

  assign accept     = s_tvalid && s_tready;
  assign at_col_end = (col >= col_last);
  assign at_row_end = (row >= row_last);
  assign tile_start = (col_phase == '0) && (row_phase == '0);
  assign tile_last  = ((col_phase == PhaseLast) || at_col_end) &&
                      ((row_phase == PhaseLast) || at_row_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      col_phase <= '0;
      row_phase <= '0;
      slot      <= '0;
    end else if (accept) begin
      if (at_row_end) begin
        row       <= '0;
        row_phase <= '0;
        slot      <= '0;
        if (at_col_end) begin
          col       <= '0;
          col_phase <= '0;
        end else begin
          col       <= col + 1'b1;
          col_phase <= (col_phase == PhaseLast) ? '0 : col_phase + 1'b1;
        end
      end else begin
        row <= row + 1'b1;
        if (row_phase == PhaseLast) begin
          row_phase <= '0;
          slot      <= slot + 1'b1;
        end else begin
          row_phase <= row_phase + 1'b1;
        end
      end
    end
  end

  // update stage: slot data arrives here, merged value is written back
  logic                        s1_valid;
  logic                        s1_fwd;
  logic                        s1_start;
  logic                        s1_last;
  logic [tmcsp_pkg::CostW-1:0] s1_cost;
  logic [CoordW-1:0]           s1_col;
  logic [CoordW-1:0]           s1_row;
  logic [SlotW-1:0]            s1_slot;
  slot_t                       band_mem [BandDepth];
  slot_t                       rd_data;
  slot_t                       last_wr;
  slot_t                       base;
  slot_t                       wr_data;
  logic                        take;
  logic                        emit;
  logic [ExtW-1:0]             x_ext;
  logic [ExtW-1:0]             y_ext;
  tmcsp_pkg::point_t           emit_point;
  logic [tmcsp_pkg::OutLvlW-1:0] fifo_level;
  tmcsp_pkg::point_t           out_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_fwd   <= accept && s1_valid && (s1_slot == slot);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cost  <= s_tdata;
      s1_col   <= col;
      s1_row   <= row;
      s1_slot  <= slot;
      s1_start <= tile_start;
      s1_last  <= tile_last;
      rd_data  <= band_mem[slot];
    end
    if (s1_valid) begin
      band_mem[s1_slot] <= wr_data;
      last_wr           <= wr_data;
    end
  end

  always_comb begin
    priority if (s1_start) begin
      base = '{cost: valid_limit, x: s1_col, y: s1_row};
    end else if (s1_fwd) begin
      base = last_wr;
    end else begin
      base = rd_data;
    end
    take    = (s1_cost < valid_limit) && (s1_cost < base.cost);
    wr_data = take ? '{cost: s1_cost, x: s1_col, y: s1_row} : base;
  end

  assign emit  = s1_valid && s1_last && (wr_data.cost < accept_limit) &&
                 (wr_data.cost < valid_limit);
  assign x_ext = ExtW'(wr_data.x);
  assign y_ext = ExtW'(wr_data.y);
  assign emit_point = '{y: y_ext[tmcsp_pkg::PointW-1:0], x: x_ext[tmcsp_pkg::PointW-1:0]};

  // room for the pixel in flight plus this one
  assign s_tready = (fifo_level + tmcsp_pkg::OutLvlW'(s1_valid)) <
                    tmcsp_pkg::OutLvlW'(tmcsp_pkg::OutDepth);

  tmcsp_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (emit),
    .push_point (emit_point),
    .level      (fifo_level),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_point  (out_point)
  );

  assign m_tdata = out_point;

  `ASSERT_CLK(a_fwd_follows_update, (s1_valid && s1_fwd) |-> $past(s1_valid), "forward without prior update")
  `ASSERT_CLK(a_phase_range, (col_phase <= PhaseLast) && (row_phase <= PhaseLast), "tile phase out of range")

endmodule

>>> design/tmcsp_out_fifo.sv
// Result queue for the support point picker: holds emitted points until taken.
// Depends on tmcsp_pkg.
`include "assert_macros.svh"

module tmcsp_out_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  tmcsp_pkg::point_t                 push_point,
  output logic [tmcsp_pkg::OutLvlW-1:0]     level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tmcsp_pkg::point_t                 out_point
);

  tmcsp_pkg::point_t                   entries [tmcsp_pkg::OutDepth];
  logic [tmcsp_pkg::OutPtrW-1:0]       wr_ptr;
  logic [tmcsp_pkg::OutPtrW-1:0]       rd_ptr;
  logic                                pop;

  assign out_valid = (level != '0);
  assign out_point = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + tmcsp_pkg::OutLvlW'(push) - tmcsp_pkg::OutLvlW'(pop);
    end
  end

  `ASSERT_NEVER(a_fifo_overflow, push && (level == tmcsp_pkg::OutLvlW'(tmcsp_pkg::OutDepth)), "result queue overflow")

endmodule
